@@ design/pcf_pkg.sv @@
// ----------------------------------------------------------------------------
// pcf_pkg: shared types, constants and CRC-32 tables for the chunk framer
// Holds the command word passed from the front end to the byte sequencer,
// and the slicing tables for the reflected CRC-32.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam int unsigned LEN_W = 31;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_DATA  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              close;
    logic [LEN_W-1:0]  length;
    logic [31:0]       ctype;
    logic [7:0]        dbyte;
    logic [31:0]       crc;
  } cmd_t;

  typedef logic [31:0] crc_tab_t [256];

  // Table for one byte position of a four-byte slice; slice 0 is the
  // ordinary byte-wise table.
  function automatic crc_tab_t crc_tab_gen(input int slice);
    crc_tab_t    t;
    crc_tab_t    base;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      t[i] = c;
    end
    base = t;
    for (int s = 0; s < slice; s++) begin
      for (int i = 0; i < 256; i++) begin
        t[i] = (t[i] >> 8) ^ base[t[i][7:0]];
      end
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TAB0 = crc_tab_gen(0);
  localparam crc_tab_t CRC_TAB1 = crc_tab_gen(1);
  localparam crc_tab_t CRC_TAB2 = crc_tab_gen(2);
  localparam crc_tab_t CRC_TAB3 = crc_tab_gen(3);

  // Byte sel of a 32-bit word, most significant byte first.
  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

@@ design/png_chunk_framer_crc32.sv @@
// ----------------------------------------------------------------------------
// png_chunk_framer_crc32: PNG chunk framer with CRC-32
// Turns start and data words into the framed byte stream of a PNG chunk.
// ----------------------------------------------------------------------------
// A start word produces eight output bytes (big-endian length, then the type),
// or twelve when the length is zero, since the CRC follows at once; a data
// word produces its byte, plus the four CRC bytes after the last declared
// byte; a data word with no chunk open produces one error byte. Input words
// are taken at one per cycle while the two-entry command queue has room, and
// the output register delivers one byte per cycle unless out_ready stalls it,
// so a stream of data words passes at one word per cycle; a start word fills
// eight or twelve output bytes. The type CRC is formed combinationally from
// four slicing tables; each data byte is folded in with one table lookup.
module png_chunk_framer_crc32 import pcf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             func,
  input  logic [LEN_W-1:0] chunk_length,
  input  logic [31:0]      chunk_type,
  input  logic [7:0]       data_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             error
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_cmd;
  cmd_t q_head;

  pcf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .chunk_length (chunk_length),
    .chunk_type   (chunk_type),
    .data_byte    (data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  pcf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  pcf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .error       (error)
  );

endmodule

@@ design/pcf_front.sv @@
// ----------------------------------------------------------------------------
// pcf_front: input acceptance and CRC tracking
// Accepts words, keeps the running CRC and byte count of the open chunk,
// and issues one command per accepted word to the sequencer queue.
// ----------------------------------------------------------------------------
module pcf_front import pcf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             func,
  input  logic [LEN_W-1:0] chunk_length,
  input  logic [31:0]      chunk_type,
  input  logic [7:0]       data_byte,
  input  logic             q_full,
  output logic             q_push,
  output cmd_t             q_cmd
);

  logic [31:0]      crc_reg;
  logic [31:0]      crc_reg_next;
  logic [LEN_W-1:0] bytes_left;
  logic [LEN_W-1:0] bytes_left_next;
  logic             chunk_open;
  logic             chunk_open_next;
  logic [31:0]      seed_word;
  logic [31:0]      seed;
  logic [31:0]      folded;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // The first type character sits in the low byte of the reflected register.
  assign seed_word = CRC_ONES ^ {chunk_type[7:0], chunk_type[15:8],
                                 chunk_type[23:16], chunk_type[31:24]};
  assign seed = CRC_TAB3[seed_word[7:0]] ^ CRC_TAB2[seed_word[15:8]] ^
                CRC_TAB1[seed_word[23:16]] ^ CRC_TAB0[seed_word[31:24]];
  assign folded = CRC_TAB0[crc_reg[7:0] ^ data_byte] ^ {8'h00, crc_reg[31:8]};

  always_comb begin
    crc_reg_next    = crc_reg;
    bytes_left_next = bytes_left;
    chunk_open_next = chunk_open;
    q_cmd.kind      = CMD_START;
    q_cmd.close     = 1'b0;
    q_cmd.length    = chunk_length;
    q_cmd.ctype     = chunk_type;
    q_cmd.dbyte     = data_byte;
    q_cmd.crc       = CRC_ONES;
    if (func == FUNC_START) begin
      if (chunk_length == '0) begin
        q_cmd.close     = 1'b1;
        q_cmd.crc       = seed ^ CRC_ONES;
        crc_reg_next    = CRC_ONES;
        bytes_left_next = '0;
        chunk_open_next = 1'b0;
      end else begin
        crc_reg_next    = seed;
        bytes_left_next = chunk_length;
        chunk_open_next = 1'b1;
      end
    end else if (!chunk_open) begin
      q_cmd.kind = CMD_ERROR;
    end else begin
      q_cmd.kind = CMD_DATA;
      if (bytes_left == LEN_W'(1)) begin
        q_cmd.close     = 1'b1;
        q_cmd.crc       = folded ^ CRC_ONES;
        crc_reg_next    = CRC_ONES;
        bytes_left_next = '0;
        chunk_open_next = 1'b0;
      end else begin
        crc_reg_next    = folded;
        bytes_left_next = bytes_left - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg    <= CRC_ONES;
      bytes_left <= '0;
      chunk_open <= 1'b0;
    end else if (q_push) begin
      crc_reg    <= crc_reg_next;
      bytes_left <= bytes_left_next;
      chunk_open <= chunk_open_next;
    end
  end

  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    chunk_open |-> (bytes_left != '0))
    else $error("open chunk with no bytes left");

endmodule

@@ design/pcf_queue.sv @@
// ----------------------------------------------------------------------------
// pcf_queue: short command queue
// A two-entry register queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module pcf_queue import pcf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

@@ design/pcf_back.sv @@
// ----------------------------------------------------------------------------
// pcf_back: byte sequencer
// Walks through the bytes of the command at the head of the queue and
// loads them one at a time into the output register.
// ----------------------------------------------------------------------------
module pcf_back import pcf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       error
);

  logic [3:0] idx;
  logic [3:0] last_idx;
  logic       load;
  logic       fire;
  logic       done;
  logic [7:0] byte_sel;
  logic [31:0] len_word;

  assign len_word = {1'b0, head.length};
  assign load  = !out_valid || out_ready;
  assign fire  = load && !q_empty;
  assign done  = (idx == last_idx);
  assign q_pop = fire && done;

  always_comb begin
    last_idx = 4'd0;
    byte_sel = 8'h00;
    unique case (head.kind)
      CMD_START: begin
        last_idx = head.close ? 4'd11 : 4'd7;
        if (idx < 4'd4) begin
          byte_sel = word_byte(len_word, idx[1:0]);
        end else if (idx < 4'd8) begin
          byte_sel = word_byte(head.ctype, idx[1:0]);
        end else begin
          byte_sel = word_byte(head.crc, idx[1:0]);
        end
      end
      CMD_DATA: begin
        last_idx = head.close ? 4'd4 : 4'd0;
        if (idx == 4'd0) begin
          byte_sel = head.dbyte;
        end else begin
          byte_sel = word_byte(head.crc, 2'(idx - 4'd1));
        end
      end
      default: begin
        last_idx = 4'd0;
        byte_sel = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= fire;
      end
      if (fire) begin
        idx <= done ? 4'd0 : idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte    <= byte_sel;
      last_of_run <= (head.kind == CMD_ERROR) || (head.close && done);
      error       <= (head.kind == CMD_ERROR);
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst) idx <= 4'd11)
    else $error("byte index out of range");
  a_idle_idx: assert property (@(posedge clk) disable iff (rst) q_empty |-> (idx == 4'd0))
    else $error("sequencer mid-command with empty queue");

endmodule
